[rtl/rgr_pkg.sv]
// Shared widths, operation codes and request/result types for the gcd-reduce core.
package rgr_pkg;

  localparam int W     = 32;
  localparam int CNT_W = $clog2(W);

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_SUB = 2'd1;
  localparam logic [1:0] FUNC_MUL = 2'd2;
  localparam logic [1:0] FUNC_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]          func;
    logic signed [W-1:0] a_num;
    logic signed [W-1:0] a_den;
    logic signed [W-1:0] b_num;
    logic signed [W-1:0] b_den;
  } rgr_req_t;

  typedef struct packed {
    logic signed [W-1:0] res_num;
    logic signed [W-1:0] res_den;
  } rgr_res_t;

endpackage

[rtl/rational_arith_gcd_reduce_core.sv]
// Rational add/sub/mul/div with gcd reduction, bit-serial datapath.
// One request at a time. Cross products are formed by three shift-add
// multipliers in parallel, the raw numerator is summed in ST_SUM, the
// gcd of the magnitudes comes from a binary gcd loop followed by shifts
// that restore common factors of two, and both magnitudes are divided by
// the gcd in two restoring dividers side by side. The time an item takes
// depends on the gcd loop and the shifts after it. A zero raw
// denominator skips the gcd and division and returns the raw pair. The
// next request is taken as soon as the result moves to the output
// register, even if that result is still stalled.
module rational_arith_gcd_reduce_core
  import rgr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  rgr_req_t req,
  output logic     res_valid,
  input  logic     res_stall,
  output rgr_res_t res
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_SUM    = 3'd2;
  localparam logic [2:0] ST_GCD    = 3'd3;
  localparam logic [2:0] ST_GSHIFT = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    return x[W-1] ? (~x + W'(1)) : x;
  endfunction

  logic [2:0]       state;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] k;
  logic [W-1:0]     mcand1, mcand2, mcand3;
  logic [W-1:0]     mplr1, mplr2, mplr3;
  logic [W-1:0]     acc1, acc2, acc3;
  logic             sub_op;
  logic [W-1:0]     u, v;
  logic [W-1:0]     qn, qd, rn, rd;
  logic             sn, sd;

  logic [W-1:0]     sum_num;
  logic [W-1:0]     tn, td;
  logic             take;

  assign req_stall = (state != ST_IDLE);
  assign take      = !res_valid || !res_stall;

  assign sum_num = sub_op ? (acc1 - acc2) : (acc1 + acc2);
  // partial remainders: previous remainder is below the divisor, so never overflows
  assign tn = {rn[W-2:0], qn[W-1]};
  assign td = {rd[W-2:0], qd[W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      // in ST_DONE the output register is either reloaded or still held
      if (res_valid && !res_stall && state != ST_DONE) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            state  <= ST_MUL;
            cnt    <= CNT_W'(W - 1);
            acc1   <= '0;
            acc2   <= '0;
            acc3   <= '0;
            sub_op <= (req.func == FUNC_SUB);
            mcand1 <= req.a_num;
            mcand2 <= req.b_num;
            mcand3 <= req.a_den;
            mplr1  <= (req.func == FUNC_MUL) ? req.b_num : req.b_den;
            mplr2  <= (req.func inside {FUNC_ADD, FUNC_SUB}) ? req.a_den : '0;
            mplr3  <= (req.func == FUNC_DIV) ? req.b_num : req.b_den;
          end
        end
        ST_MUL: begin
          acc1   <= acc1 + (mplr1[0] ? mcand1 : '0);
          acc2   <= acc2 + (mplr2[0] ? mcand2 : '0);
          acc3   <= acc3 + (mplr3[0] ? mcand3 : '0);
          mcand1 <= {mcand1[W-2:0], 1'b0};
          mcand2 <= {mcand2[W-2:0], 1'b0};
          mcand3 <= {mcand3[W-2:0], 1'b0};
          mplr1  <= {1'b0, mplr1[W-1:1]};
          mplr2  <= {1'b0, mplr2[W-1:1]};
          mplr3  <= {1'b0, mplr3[W-1:1]};
          cnt    <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          rn <= '0;
          rd <= '0;
          k  <= '0;
          if (acc3 == '0) begin
            // zero denominator: raw pair goes out unreduced
            qn    <= sum_num;
            qd    <= acc3;
            sn    <= 1'b0;
            sd    <= 1'b0;
            state <= ST_DONE;
          end else begin
            qn    <= mag(sum_num);
            qd    <= mag(acc3);
            u     <= mag(sum_num);
            v     <= mag(acc3);
            sn    <= sum_num[W-1];
            sd    <= acc3[W-1];
            state <= ST_GCD;
          end
        end
        ST_GCD: begin
          // binary gcd; v stays nonzero, loop ends when u reaches zero
          if (u == '0) begin
            state <= ST_GSHIFT;
          end else if (!u[0] && !v[0]) begin
            u <= {1'b0, u[W-1:1]};
            v <= {1'b0, v[W-1:1]};
            k <= k + CNT_W'(1);
          end else if (!u[0]) begin
            u <= {1'b0, u[W-1:1]};
          end else if (!v[0]) begin
            v <= {1'b0, v[W-1:1]};
          end else if (u >= v) begin
            u <= (u - v) >> 1;
          end else begin
            v <= (v - u) >> 1;
          end
        end
        ST_GSHIFT: begin
          if (k == '0) begin
            state <= ST_DIV;
            cnt   <= CNT_W'(W - 1);
          end else begin
            v <= {v[W-2:0], 1'b0};
            k <= k - CNT_W'(1);
          end
        end
        ST_DIV: begin
          if (tn >= v) begin
            rn <= tn - v;
            qn <= {qn[W-2:0], 1'b1};
          end else begin
            rn <= tn;
            qn <= {qn[W-2:0], 1'b0};
          end
          if (td >= v) begin
            rd <= td - v;
            qd <= {qd[W-2:0], 1'b1};
          end else begin
            rd <= td;
            qd <= {qd[W-2:0], 1'b0};
          end
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (take) begin
            res_valid   <= 1'b1;
            res.res_num <= sn ? (~qn + W'(1)) : qn;
            res.res_den <= sd ? (~qd + W'(1)) : qd;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/rgr_checker.sv]
// Port-level checks for the gcd-reduce core, bound to the core module.
module rgr_checker
  import rgr_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_stall,
  input rgr_req_t req,
  input logic     res_valid,
  input logic     res_stall,
  input rgr_res_t res
);

  // a taken request keeps the core busy on the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("core not busy after request");

  // no result can appear right after a request is taken
  a_no_instant_res: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> !$rose(res_valid))
    else $error("result appeared too early");

  a_res_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res)))
    else $error("stalled result dropped or changed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind rational_arith_gcd_reduce_core rgr_checker u_rgr_checker (.*);

[bench/tb.sv]
// Self-checking bench for the rational add/sub/mul/div core with gcd reduction.
`timescale 1ns / 100ps

module tb;
  import rgr_pkg::*;

  localparam int N_RAND    = 1330;
  localparam int N_DIR     = 23;
  localparam int LIMIT     = 1500000;
  localparam int HOLD_CYC  = 3000;
  localparam int DRAIN_CYC = 200;

  localparam logic [W-1:0] V_MAX  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] V_MIN  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] V_NEG1 = '1;

  typedef struct {
    logic [1:0]   func;
    logic [W-1:0] an, ad, bn, bd;
    bit           typed;
    logic [W-1:0] en, ed;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  rgr_req_t req = '0;
  logic     res_valid;
  logic     res_stall = 1'b0;
  rgr_res_t res;

  rgr_res_t req_want = '0;   // expected result of the request now on the bus
  rgr_res_t quot_q[$];
  rgr_res_t head;
  dir_row_t dir_tab [N_DIR];
  int       n_bad = 0;
  int       n_taken = 0;
  int       burst_left = 0;
  int       cyc = 0;

  rational_arith_gcd_reduce_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [W-1:0] mag_of(logic [W-1:0] x);
    return x[W-1] ? -x : x;
  endfunction

  function automatic logic [W-1:0] gcd_of(logic [W-1:0] p, logic [W-1:0] q);
    logic [W-1:0] r;
    while (q != '0) begin
      r = p % q;
      p = q;
      q = r;
    end
    return p;
  endfunction

  function automatic logic [W-1:0] div_signed(logic [W-1:0] x, logic [W-1:0] g);
    logic [W-1:0] qt;
    qt = mag_of(x) / g;
    return x[W-1] ? -qt : qt;
  endfunction

  function automatic rgr_res_t reduce_frac(rgr_req_t r);
    logic [W-1:0] an, ad, bn, bd, nm, dn, g;
    rgr_res_t o;
    an = r.a_num;
    ad = r.a_den;
    bn = r.b_num;
    bd = r.b_den;
    nm = '0;
    dn = '0;
    case (r.func)
      FUNC_ADD: begin
        nm = an * bd + bn * ad;
        dn = ad * bd;
      end
      FUNC_SUB: begin
        nm = an * bd - bn * ad;
        dn = ad * bd;
      end
      FUNC_MUL: begin
        nm = an * bn;
        dn = ad * bd;
      end
      FUNC_DIV: begin
        nm = an * bd;
        dn = ad * bn;
      end
      default: ;
    endcase
    // zero denominator passes the raw pair through
    if (dn != '0) begin
      g  = gcd_of(mag_of(nm), mag_of(dn));
      nm = div_signed(nm, g);
      dn = div_signed(dn, g);
    end
    o.res_num = nm;
    o.res_den = dn;
    return o;
  endfunction

  function automatic logic [W-1:0] pick_val();
    logic [W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom_range(0, 100) - 50;
      3, 4:    v = $urandom();
      5: begin
        case ($urandom_range(0, 5))
          0:       v = '0;
          1:       v = 1;
          2:       v = V_NEG1;
          3:       v = V_MAX;
          4:       v = V_MIN;
          default: v = V_MIN + 1;
        endcase
      end
      6: begin
        v = $urandom_range(1, 255) << $urandom_range(0, 20);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      7, 8:    v = $urandom_range(0, 131070) - 65535;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic rgr_req_t rand_req();
    rgr_req_t r;
    r.func  = 2'($urandom_range(0, 3));
    r.a_num = pick_val();
    r.a_den = pick_val();
    r.b_num = pick_val();
    r.b_den = pick_val();
    return r;
  endfunction

  task automatic report(string what, rgr_res_t e, rgr_res_t a);
    n_bad++;
    if (n_bad <= 10)
      $display("%s: expected %h/%h (%0d/%0d), got %h/%h (%0d/%0d)", what,
               e.res_num, e.res_den, e.res_num, e.res_den,
               a.res_num, a.res_den, a.res_num, a.res_den);
  endtask

  // request stays on the bus until taken; bursts end in a random gap, which may be empty
  task automatic offer(rgr_req_t r, rgr_res_t e);
    int gap;
    req       <= r;
    req_want  <= e;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 6);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200)
                                        : $urandom_range(0, 4);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin
    cyc++;
    if (cyc == LIMIT) begin
      $display("[rational_arith_gcd_reduce_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) begin
      quot_q.push_back(req_want);
      n_taken++;
    end
    if (!rst && res_valid && !res_stall) begin
      if (quot_q.size() == 0) begin
        report("unexpected result", '0, res);
      end else begin
        head = quot_q.pop_front();
        if (head.res_num !== res.res_num || head.res_den !== res.res_den)
          report("mismatch", head, res);
      end
    end
  end

  // receiver: segments of no stall, light stall and heavy stall, one long hold
  initial begin
    int  seg;
    int  mode;
    bit  held;
    held = 1'b0;
    forever begin
      seg  = $urandom_range(50, 500);
      mode = $urandom_range(0, 2);
      repeat (seg) begin
        @(posedge clk);
        if (!held && n_taken >= 300) begin
          held = 1'b1;
          res_stall <= 1'b1;
          repeat (HOLD_CYC) @(posedge clk);
        end
        case (mode)
          0:       res_stall <= 1'b0;
          1:       res_stall <= ($urandom_range(0, 3) == 0);
          default: res_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    rgr_req_t r;
    rgr_res_t e;

    dir_tab[0]  = '{FUNC_ADD, 0, 0, 0, 0, 1'b1, 0, 0};
    dir_tab[1]  = '{FUNC_ADD, 1, 2, 1, 3, 1'b0, 0, 0};
    dir_tab[2]  = '{FUNC_SUB, 1, 2, 1, 3, 1'b0, 0, 0};
    dir_tab[3]  = '{FUNC_MUL, 2, 3, 3, 4, 1'b0, 0, 0};
    dir_tab[4]  = '{FUNC_DIV, 1, 2, 3, 4, 1'b0, 0, 0};
    dir_tab[5]  = '{FUNC_ADD, 1, -2, 1, 3, 1'b0, 0, 0};
    dir_tab[6]  = '{FUNC_DIV, 3, 1, 0, 5, 1'b1, 15, 0};
    dir_tab[7]  = '{FUNC_MUL, 7, 0, 3, 2, 1'b1, 21, 0};
    dir_tab[8]  = '{FUNC_SUB, 3, 4, 3, 4, 1'b1, 0, 1};
    dir_tab[9]  = '{FUNC_MUL, 0, 1, 5, -1, 1'b1, 0, V_NEG1};
    dir_tab[10] = '{FUNC_MUL, V_MIN, 1, 1, 1, 1'b1, V_MIN, 1};
    dir_tab[11] = '{FUNC_MUL, V_MIN, 2, 1, 1, 1'b1, {2'b11, {(W-2){1'b0}}}, 1};
    dir_tab[12] = '{FUNC_MUL, V_MIN, V_MIN, 1, 1, 1'b1, V_NEG1, V_NEG1};
    dir_tab[13] = '{FUNC_ADD, V_MAX, 1, 1, 1, 1'b1, V_MIN, 1};
    dir_tab[14] = '{FUNC_MUL, V_MAX, V_MAX, V_MAX, V_MAX, 1'b1, 1, 1};
    dir_tab[15] = '{FUNC_DIV, V_NEG1, V_NEG1, V_NEG1, V_NEG1, 1'b0, 0, 0};
    dir_tab[16] = '{FUNC_ADD, V_MIN, V_MIN, V_MIN, V_MIN, 1'b1, 0, 0};
    dir_tab[17] = '{FUNC_SUB, V_MAX, V_NEG1, V_MIN, 3, 1'b0, 0, 0};
    dir_tab[18] = '{FUNC_DIV, 12, -18, -4, 6, 1'b0, 0, 0};
    dir_tab[19] = '{FUNC_MUL, V_MIN, V_NEG1, V_NEG1, V_MIN, 1'b0, 0, 0};
    dir_tab[20] = '{FUNC_ADD, V_NEG1, 1, 1, 1, 1'b1, 0, 1};
    dir_tab[21] = '{FUNC_MUL, 6, 4, 10, -15, 1'b0, 0, 0};
    dir_tab[22] = '{FUNC_DIV, V_MAX, V_MIN, V_MIN, V_MAX, 1'b0, 0, 0};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < N_DIR; k++) begin
      r.func  = dir_tab[k].func;
      r.a_num = dir_tab[k].an;
      r.a_den = dir_tab[k].ad;
      r.b_num = dir_tab[k].bn;
      r.b_den = dir_tab[k].bd;
      if (dir_tab[k].typed) begin
        e.res_num = dir_tab[k].en;
        e.res_den = dir_tab[k].ed;
      end else begin
        e = reduce_frac(r);
      end
      offer(r, e);
    end

    for (int k = 0; k < N_RAND; k++) begin
      r = rand_req();
      offer(r, reduce_frac(r));
    end

    req_valid <= 1'b0;
    while (quot_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (n_bad == 0)
      $display("[rational_arith_gcd_reduce_core] OK");
    else
      $display("[rational_arith_gcd_reduce_core] ERROR");
    $finish;
  end

endmodule

[sim.f]
rtl/rgr_pkg.sv
rtl/rational_arith_gcd_reduce_core.sv
rtl/rgr_checker.sv
bench/tb.sv
